FILE: sv/double_hash_key_set_top_macros.svh
// assertion macros for the double hash key set
// used by dhks_rem_unit and double_hash_key_set_top; no other dependencies
`ifndef DOUBLE_HASH_KEY_SET_TOP_MACROS_SVH
`define DOUBLE_HASH_KEY_SET_TOP_MACROS_SVH
`ifndef SYNTH
// a holds in a cycle -> b holds in the same cycle
`define DHKS_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("dhks assertion failed");
// a holds in a cycle -> b holds in the next cycle
`define DHKS_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("dhks assertion failed");
`else
`define DHKS_ASSERT_IMP(label, clk, rst_n, a, b)
`define DHKS_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: sv/dhks_pkg.sv
// shared types and constants of the double hash key set
// no dependencies
package dhks_pkg;

  localparam int unsigned DEPTH_DEF          = 4096;
  localparam int unsigned STRIDE_MODULUS_DEF = 11;

  localparam int unsigned KEY_W      = 63;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned KEY_DIGITS = DIVIDEND_W / DIGIT_BITS;
  localparam int unsigned STEP_DIGITS = 2;
  localparam int unsigned STEP_FIELD_W = STEP_DIGITS * DIGIT_BITS;
  localparam int unsigned DIG_CNT_W  = $clog2(KEY_DIGITS);

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 12'd4093;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_PRESENT   = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV_KEY,
    ST_STEP_LOAD,
    ST_DIV_STEP,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic run;
  } dhks_rem_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } dhks_entry_t;

endpackage

FILE: sv/dhks_rem_unit.sv
// shared remainder unit: four dividend bits per cycle while run is set, msb first
// reduces modulo the table size and modulo the stride modulus; uses dhks_pkg
`include "double_hash_key_set_top_macros.svh"
module dhks_rem_unit
  import dhks_pkg::*;
#(
  parameter int unsigned STRIDE_MODULUS = STRIDE_MODULUS_DEF,
  localparam int unsigned MW = $clog2(STRIDE_MODULUS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhks_rem_ctrl_t        ctrl_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0]     divisor_i,
  output logic [SIZE_W-1:0]     rem_o,
  output logic [MW-1:0]         rem_m_o
);

  localparam logic [MW:0] MOD_W = (MW + 1)'(STRIDE_MODULUS);

  logic [DIVIDEND_W-1:0] shreg_q;
  logic [SIZE_W-1:0]     rem_q, rem_d;
  logic [MW-1:0]         remm_q, remm_d;

  always_comb begin
    logic [SIZE_W:0] r;
    logic [MW:0]     rm;
    r  = {1'b0, rem_q};
    rm = {1'b0, remm_q};
    // restoring steps, partial remainder always below twice the divisor
    for (int i = 0; i < DIGIT_BITS; i++) begin
      r = {r[SIZE_W-1:0], shreg_q[DIVIDEND_W-1-i]};
      if (r >= {1'b0, divisor_i}) begin
        r = r - {1'b0, divisor_i};
      end
      rm = {rm[MW-1:0], shreg_q[DIVIDEND_W-1-i]};
      if (rm >= MOD_W) begin
        rm = rm - MOD_W;
      end
    end
    rem_d  = r[SIZE_W-1:0];
    remm_d = rm[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      shreg_q <= dividend_i;
      rem_q   <= '0;
      remm_q  <= '0;
    end else if (ctrl_i.run) begin
      shreg_q <= shreg_q << DIGIT_BITS;
      rem_q   <= rem_d;
      remm_q  <= remm_d;
    end
  end

  assign rem_o   = rem_q;
  assign rem_m_o = remm_q;

  `DHKS_ASSERT_NXT(a_rem_below_divisor, clk_i, rst_ni, ctrl_i.run, rem_q < divisor_i)

endmodule

FILE: sv/dhks_key_ram.sv
// key table memory: one write port, one registered read port
// entry type from dhks_pkg
module dhks_key_ram
  import dhks_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [AW-1:0] waddr_i,
  input  dhks_entry_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output dhks_entry_t rdata_o
);

  dhks_entry_t mem [DEPTH];
  dhks_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/double_hash_key_set_top.sv
// double hash key set: sequencer, size register, probe datapath and result register
// uses dhks_pkg, dhks_rem_unit, dhks_key_ram
//
//  channel  | signals                              | beat
//  ---------+--------------------------------------+----------------------------
//  in       | in_valid_i in_ready_o opcode_i key_i | one command
//  out      | out_valid_o out_ready_i status_o slot_o | one status and slot
//  cfg      | cfg_we_i cfg_wdata_i                 | table_size, write only
//
// insert and lookup: the key remainder (4 bits a cycle in the shared
// remainder unit), then the stride, then per probe a memory read and a
// compare, then the result.
// clear: one pass over all DEPTH entries, one a cycle, then the result.
// after reset the same pass runs before in_ready_o rises.
// a finished result waits in the output register; the next command is taken
// meanwhile and holds only at its own result until the register is free.
`include "double_hash_key_set_top_macros.svh"
module double_hash_key_set_top
  import dhks_pkg::*;
#(
  parameter int unsigned DEPTH          = DEPTH_DEF,
  parameter int unsigned STRIDE_MODULUS = STRIDE_MODULUS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [SIZE_W-1:0] slot_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned MW   = $clog2(STRIDE_MODULUS);
  localparam int unsigned NCAP = (DEPTH > 4095) ? 4095 : DEPTH;
  localparam logic [SIZE_W-1:0] NCAP_W   = SIZE_W'(NCAP);
  localparam logic [AW-1:0]     SWEEP_END = AW'(DEPTH - 1);

  state_e state_q, state_d;

  logic [SIZE_W-1:0]    ts_q;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic [DIG_CNT_W-1:0] dig_q, dig_d;
  logic                 out_valid_q, out_valid_d;

  logic                 is_insert_q, is_insert_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [SIZE_W-1:0]    n_q, n_d;
  logic [SIZE_W-1:0]    pos_q, pos_d;
  logic [SIZE_W-1:0]    cnt_q, cnt_d;
  status_e              res_status_q, res_status_d;
  logic [SIZE_W-1:0]    res_slot_q, res_slot_d;
  logic [2:0]           out_status_q, out_status_d;
  logic [SIZE_W-1:0]    out_slot_q, out_slot_d;

  dhks_rem_ctrl_t        rem_ctrl;
  logic [DIVIDEND_W-1:0] rem_dividend;
  logic [SIZE_W-1:0]     rem_n;
  logic [MW-1:0]         rem_m;
  logic [STEP_FIELD_W-1:0] stride;

  logic         mem_we;
  logic [AW-1:0] mem_waddr;
  dhks_entry_t  mem_wdata;
  dhks_entry_t  mem_rdata;

  logic              in_beat;
  logic              hit;
  logic              last_probe;
  logic [SIZE_W:0]   pos_sum;
  logic [SIZE_W-1:0] pos_next;
  logic [SIZE_W-1:0] n_eff;
  logic              out_free;

  dhks_rem_unit #(
    .STRIDE_MODULUS(STRIDE_MODULUS)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rem_ctrl),
    .dividend_i(rem_dividend),
    .divisor_i (n_q),
    .rem_o     (rem_n),
    .rem_m_o   (rem_m)
  );

  dhks_key_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(AW'(pos_q)),
    .rdata_o(mem_rdata)
  );

  assign in_beat    = in_valid_i && in_ready_o;
  assign hit        = mem_rdata.valid && (mem_rdata.key == key_q);
  assign last_probe = (cnt_q == n_q - SIZE_W'(1));
  assign out_free   = !out_valid_q || out_ready_i;
  // rem_n holds the stride while probing; step and pos both below n
  assign pos_sum    = {1'b0, pos_q} + {1'b0, rem_n};
  assign pos_next   = (pos_sum >= {1'b0, n_q}) ? SIZE_W'(pos_sum - {1'b0, n_q})
                                               : pos_sum[SIZE_W-1:0];
  assign stride     = STEP_FIELD_W'(rem_m) + STEP_FIELD_W'(1);

  always_comb begin
    if (ts_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (ts_q > NCAP_W) begin
      n_eff = NCAP_W;
    end else begin
      n_eff = ts_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == SWEEP_END) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_beat) begin
          unique case (opcode_i) inside
            OP_INSERT, OP_LOOKUP: state_d = ST_DIV_KEY;
            OP_CLEAR:             state_d = ST_CLEAR;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV_KEY: begin
        if (dig_q == DIG_CNT_W'(KEY_DIGITS - 1)) state_d = ST_STEP_LOAD;
      end
      ST_STEP_LOAD: state_d = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (dig_q == DIG_CNT_W'(STEP_DIGITS - 1)) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (!mem_rdata.valid || hit || last_probe) state_d = ST_DONE;
        else                                       state_d = ST_READ;
      end
      ST_CLEAR: begin
        if (sweep_q == SWEEP_END) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o    = 1'b0;
    rem_ctrl      = '0;
    rem_dividend  = {1'b0, key_i};
    mem_we        = 1'b0;
    mem_waddr     = sweep_q;
    mem_wdata     = '0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        rem_ctrl.load = in_beat;
      end
      ST_DIV_KEY, ST_DIV_STEP: begin
        rem_ctrl.run = 1'b1;
      end
      ST_STEP_LOAD: begin
        // second pass: stride value sits in the top digits
        rem_ctrl.load = 1'b1;
        rem_dividend  = {stride, (DIVIDEND_W - STEP_FIELD_W)'(0)};
      end
      ST_CHECK: begin
        if (!mem_rdata.valid && is_insert_q) begin
          mem_we          = 1'b1;
          mem_waddr       = AW'(pos_q);
          mem_wdata.valid = 1'b1;
          mem_wdata.key   = key_q;
        end
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    sweep_d      = sweep_q;
    dig_d        = dig_q;
    out_valid_d  = out_valid_q;
    is_insert_d  = is_insert_q;
    key_d        = key_q;
    n_d          = n_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == SWEEP_END) begin
          sweep_d      = '0;
          res_status_d = STAT_CLEARED;
          res_slot_d   = '0;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          is_insert_d  = (opcode_i == OP_INSERT);
          key_d        = key_i;
          n_d          = n_eff;
          dig_d        = '0;
          sweep_d      = '0;
          res_status_d = STAT_NOT_FOUND;
          res_slot_d   = '0;
        end
      end
      ST_DIV_KEY: begin
        dig_d = dig_q + DIG_CNT_W'(1);
        if (dig_q == DIG_CNT_W'(KEY_DIGITS - 1)) dig_d = '0;
      end
      ST_STEP_LOAD: begin
        pos_d = rem_n;
        cnt_d = '0;
      end
      ST_DIV_STEP: begin
        dig_d = dig_q + DIG_CNT_W'(1);
      end
      ST_CHECK: begin
        if (!mem_rdata.valid) begin
          if (is_insert_q) begin
            res_status_d = STAT_INSERTED;
            res_slot_d   = pos_q;
          end else begin
            res_status_d = STAT_NOT_FOUND;
            res_slot_d   = '0;
          end
        end else if (hit) begin
          res_status_d = STAT_PRESENT;
          res_slot_d   = pos_q;
        end else if (last_probe) begin
          if (is_insert_q) begin
            res_status_d = STAT_FULL;
          end else begin
            res_status_d = STAT_NOT_FOUND;
          end
          res_slot_d   = '0;
        end else begin
          pos_d = pos_next;
          cnt_d = cnt_q + SIZE_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ts_q        <= TABLE_SIZE_RST;
      sweep_q     <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) ts_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    is_insert_q  <= is_insert_d;
    key_q        <= key_d;
    n_q          <= n_d;
    pos_q        <= pos_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;

  `DHKS_ASSERT_IMP(a_pos_in_table, clk_i, rst_ni,
                   (state_q == ST_READ) || (state_q == ST_CHECK), pos_q < n_q)
  `DHKS_ASSERT_IMP(a_cnt_in_limit, clk_i, rst_ni, state_q == ST_CHECK, cnt_q < n_q)
  `DHKS_ASSERT_IMP(a_write_only_empty, clk_i, rst_ni,
                   (state_q == ST_CHECK) && mem_we, is_insert_q && !mem_rdata.valid)
  `DHKS_ASSERT_NXT(a_result_waits, clk_i, rst_ni,
                   (state_q == ST_DONE) && out_valid_q && !out_ready_i, state_q == ST_DONE)

endmodule
